// File: rtl/core/emot_pkg.sv
// Shared types and codes for the extent map overwrite table.
// No dependencies; used by the top level and the port checker.
`default_nettype none

package emot_pkg;

   // packed word widths on the stream ports
   localparam int unsigned REQ_DATA_W = 296;
   localparam int unsigned RSP_DATA_W = 368;

   typedef enum logic [1:0] {
      KIND_OVERWRITE = 2'd0,
      KIND_APPEND    = 2'd1,
      KIND_TRUNCATE  = 2'd2,
      KIND_READ      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_INVALID  = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_OVERFLOW = 3'd3,
      STATUS_RANGE    = 3'd4
   } status_type;

   // one table entry as held in memory
   typedef struct packed {
      logic [63:0] start;
      logic [63:0] length;
      logic [63:0] obj_offset;
      logic [31:0] tag;
   } extent_type;

   localparam int unsigned EXTENT_W = $bits(extent_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_READ_REQ,
      ST_READ_DATA,
      ST_WALK_REQ,
      ST_WALK_EVAL,
      ST_WALK_WR,
      ST_WALK_END,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/emot_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module emot_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/extent_map_overwrite_table.sv
// A write error or a read past the held entries goes straight to the reply; a read fetches
// its entry first; an insert or truncate walks every held entry, reading and evaluating it,
// then writing each piece it turns into (up to 3 per entry); an insert not yet placed is
// written after the last entry. The walk over the extent memory sets the time taken.
// One word is in work at a time; the next is taken while a reply waits to be taken.
// Synchronous reset clears count, size, append start and bank; memories are not cleared.
// Depends on emot_pkg and emot_ram.
`default_nettype none

module extent_map_overwrite_table #(
   parameter int unsigned MAX_EXTENTS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // batch_start, offset, length, obj_offset, object_tag, new_size, entry_index, pad
   input  wire logic [emot_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status, file_size, extent_count, placed_offset, entry_start, entry_length,
   // entry_obj_offset, entry_object_tag, pad
   output logic      [emot_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
   localparam int unsigned IW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

   emot_pkg::state_type state_ff, state_in;

   // item fields
   emot_pkg::kind_type kind_ff;
   logic        bstart_ff;
   logic [63:0] off_ff, len_ff, obj_ff, ns_ff;
   logic [31:0] tag_ff;
   logic [5:0]  idx_ff;

   // working values
   logic [63:0] s_ff, e_ff, base_ff;
   logic        ovf_ff;

   // architectural state outside the memories
   logic [63:0]   size_ff, append_ff;
   logic [CW-1:0] held_ff;
   logic          bank_ff;

   // walk control
   logic [CW-1:0] rd_ptr_ff, wr_cnt_ff;
   logic          full_ff, placed_ff;
   emot_pkg::extent_type piece_ff [3];
   logic [1:0]    npiece_ff, wsel_ff;

   // result staging
   emot_pkg::status_type res_status_ff;
   emot_pkg::extent_type ent_ff;

   // reply register
   logic                 rsp_valid_ff;
   emot_pkg::status_type rsp_status_ff;
   logic [63:0]          rsp_size_ff, rsp_placed_ff;
   logic [6:0]           rsp_count_ff;
   emot_pkg::extent_type rsp_ent_ff;

   // memory ports
   logic [AW-1:0]                  rd_addr, wr_addr;
   logic                           wr_en;
   logic [emot_pkg::EXTENT_W-1:0]  rd_data_a, rd_data_b;
   emot_pkg::extent_type           cur, wr_piece;

   // combinational helpers
   logic        accept, rsp_free;
   logic [63:0] base_c, s_c, e_c;
   logic        ovf_c;
   logic        idx_ok;
   emot_pkg::extent_type pc_piece [3];
   emot_pkg::extent_type new_piece;
   logic [1:0]  pc_count;
   logic        pc_placed;
   logic [63:0] oe, trunc_len;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // two banks: one holds the table, the other receives the rebuilt table
   emot_ram #(.WIDTH(emot_pkg::EXTENT_W), .DEPTH(MAX_EXTENTS)) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_piece),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   emot_ram #(.WIDTH(emot_pkg::EXTENT_W), .DEPTH(MAX_EXTENTS)) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_piece),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   assign cur = bank_ff ? emot_pkg::extent_type'(rd_data_b) : emot_pkg::extent_type'(rd_data_a);

   // start and end of placement, overflow of the append base add and the end add, read index range check
   always_comb begin
      base_c = bstart_ff ? size_ff : append_ff;
      s_c    = (kind_ff == emot_pkg::KIND_APPEND) ? base_c + off_ff : off_ff;
      e_c    = s_ff + len_ff;
      ovf_c  = ovf_ff || (e_c < s_ff) || ((len_ff != 64'd0) && (e_c == 64'd0));
      idx_ok = IW'(idx_ff) < IW'(held_ff);
   end

   // pieces that one old entry turns into
   always_comb begin
      new_piece = '{start: s_ff, length: len_ff, obj_offset: obj_ff, tag: tag_ff};
      pc_piece  = '{default: '0};
      pc_count  = 2'd0;
      pc_placed = placed_ff;
      oe        = cur.start + cur.length;
      trunc_len = ns_ff - cur.start;
      if (kind_ff == emot_pkg::KIND_TRUNCATE) begin
         if (cur.start < ns_ff) begin
            pc_piece[0] = cur;
            if (cur.length > trunc_len) begin
               pc_piece[0].length = trunc_len;
            end
            pc_count = 2'd1;
         end
      end else if (!(cur.start < e_ff && s_ff < oe)) begin
         if (!pc_placed && cur.start >= s_ff) begin
            pc_piece[pc_count] = new_piece;
            pc_count  = pc_count + 2'd1;
            pc_placed = 1'b1;
         end
         pc_piece[pc_count] = cur;
         pc_count = pc_count + 2'd1;
      end else begin
         if (cur.start < s_ff) begin
            pc_piece[pc_count] = '{start: cur.start, length: s_ff - cur.start,
                                   obj_offset: cur.obj_offset, tag: cur.tag};
            pc_count = pc_count + 2'd1;
         end
         if (!pc_placed) begin
            pc_piece[pc_count] = new_piece;
            pc_count  = pc_count + 2'd1;
            pc_placed = 1'b1;
         end
         if (e_ff < oe) begin
            pc_piece[pc_count] = '{start: e_ff, length: oe - e_ff,
                                   obj_offset: cur.obj_offset + (e_ff - cur.start),
                                   tag: cur.tag};
            pc_count = pc_count + 2'd1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         emot_pkg::ST_IDLE: begin
            if (accept) state_in = emot_pkg::ST_PREP;
         end
         emot_pkg::ST_PREP: begin
            unique case (kind_ff)
               emot_pkg::KIND_READ:     state_in = emot_pkg::ST_READ_REQ;
               emot_pkg::KIND_TRUNCATE: state_in = emot_pkg::ST_WALK_REQ;
               default:                 state_in = emot_pkg::ST_CHECK;
            endcase
         end
         emot_pkg::ST_CHECK: begin
            if (len_ff == 64'd0 || tag_ff == 32'd0 || ovf_c) state_in = emot_pkg::ST_DONE;
            else state_in = emot_pkg::ST_WALK_REQ;
         end
         emot_pkg::ST_READ_REQ: begin
            state_in = idx_ok ? emot_pkg::ST_READ_DATA : emot_pkg::ST_DONE;
         end
         emot_pkg::ST_READ_DATA: state_in = emot_pkg::ST_DONE;
         emot_pkg::ST_WALK_REQ: begin
            state_in = (rd_ptr_ff == held_ff) ? emot_pkg::ST_WALK_END : emot_pkg::ST_WALK_EVAL;
         end
         emot_pkg::ST_WALK_EVAL: begin
            state_in = (pc_count == 2'd0) ? emot_pkg::ST_WALK_REQ : emot_pkg::ST_WALK_WR;
         end
         emot_pkg::ST_WALK_WR: begin
            if (wsel_ff == npiece_ff - 2'd1) state_in = emot_pkg::ST_WALK_REQ;
         end
         emot_pkg::ST_WALK_END: begin
            if (kind_ff != emot_pkg::KIND_TRUNCATE && !placed_ff) state_in = emot_pkg::ST_WALK_WR;
            else state_in = emot_pkg::ST_DONE;
         end
         emot_pkg::ST_DONE: begin
            if (rsp_free) state_in = emot_pkg::ST_IDLE;
         end
         default: state_in = emot_pkg::ST_IDLE;
      endcase
   end

   // memory port drive and handshake outputs
   always_comb begin
      req_tready = (state_ff == emot_pkg::ST_IDLE);
      rd_addr    = rd_ptr_ff[AW-1:0];
      if (state_ff == emot_pkg::ST_READ_REQ) rd_addr = AW'(idx_ff);
      wr_addr    = wr_cnt_ff[AW-1:0];
      wr_piece   = piece_ff[wsel_ff];
      wr_en      = (state_ff == emot_pkg::ST_WALK_WR) && (wr_cnt_ff != MAX_CNT);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emot_pkg::ST_IDLE;
         size_ff      <= 64'd0;
         append_ff    <= 64'd0;
         held_ff      <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == emot_pkg::ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         // commit the rebuilt table
         if (state_ff == emot_pkg::ST_WALK_END && state_in == emot_pkg::ST_DONE) begin
            if (kind_ff == emot_pkg::KIND_TRUNCATE) begin
               bank_ff <= !bank_ff;
               held_ff <= wr_cnt_ff;
               size_ff <= ns_ff;
            end else if (!full_ff) begin
               bank_ff <= !bank_ff;
               held_ff <= wr_cnt_ff;
               if (e_ff > size_ff) size_ff <= e_ff;
               if (kind_ff == emot_pkg::KIND_APPEND) append_ff <= base_ff;
            end
         end
      end
   end

   // item, walk and reply registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= emot_pkg::kind_type'(req_tuser);
         bstart_ff <= req_tdata[0];
         off_ff    <= req_tdata[64:1];
         len_ff    <= req_tdata[128:65];
         obj_ff    <= req_tdata[192:129];
         tag_ff    <= req_tdata[224:193];
         ns_ff     <= req_tdata[288:225];
         idx_ff    <= req_tdata[294:289];
      end
      unique case (state_ff)
         emot_pkg::ST_PREP: begin
            base_ff       <= base_c;
            s_ff          <= s_c;
            ovf_ff        <= (kind_ff == emot_pkg::KIND_APPEND) && (s_c < base_c);
            rd_ptr_ff     <= '0;
            wr_cnt_ff     <= '0;
            full_ff       <= 1'b0;
            placed_ff     <= 1'b0;
            res_status_ff <= emot_pkg::STATUS_OK;
            ent_ff        <= '0;
         end
         emot_pkg::ST_CHECK: begin
            e_ff <= e_c;
            if (len_ff == 64'd0 || tag_ff == 32'd0) res_status_ff <= emot_pkg::STATUS_INVALID;
            else if (ovf_c) res_status_ff <= emot_pkg::STATUS_OVERFLOW;
         end
         emot_pkg::ST_READ_REQ: begin
            if (!idx_ok) res_status_ff <= emot_pkg::STATUS_RANGE;
         end
         emot_pkg::ST_READ_DATA: ent_ff <= cur;
         emot_pkg::ST_WALK_EVAL: begin
            piece_ff  <= pc_piece;
            npiece_ff <= pc_count;
            placed_ff <= pc_placed;
            wsel_ff   <= 2'd0;
            rd_ptr_ff <= rd_ptr_ff + CW'(1);
         end
         emot_pkg::ST_WALK_WR: begin
            if (wr_cnt_ff == MAX_CNT) full_ff <= 1'b1;
            else wr_cnt_ff <= wr_cnt_ff + CW'(1);
            wsel_ff <= wsel_ff + 2'd1;
         end
         emot_pkg::ST_WALK_END: begin
            piece_ff[0] <= new_piece;
            npiece_ff   <= 2'd1;
            wsel_ff     <= 2'd0;
            placed_ff   <= 1'b1;
            if (kind_ff != emot_pkg::KIND_TRUNCATE && placed_ff && full_ff) begin
               res_status_ff <= emot_pkg::STATUS_FULL;
            end
         end
         emot_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_size_ff   <= size_ff;
               rsp_count_ff  <= 7'(held_ff);
               rsp_placed_ff <= (kind_ff != emot_pkg::KIND_TRUNCATE &&
                                 kind_ff != emot_pkg::KIND_READ &&
                                 res_status_ff == emot_pkg::STATUS_OK) ? s_ff : 64'd0;
               rsp_ent_ff    <= ent_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ent_ff.tag, rsp_ent_ff.obj_offset, rsp_ent_ff.length,
                        rsp_ent_ff.start, rsp_placed_ff, rsp_count_ff, rsp_size_ff,
                        rsp_status_ff};

endmodule

`default_nettype wire

// File: rtl/core/emot_checker.sv
// Port checker for extent_map_overwrite_table, bound to the top level.
// Depends on emot_pkg.
`default_nettype none

module emot_checker #(
   parameter int unsigned MAX_EXTENTS = 64
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [emot_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled reply word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("reply word changed while stalled");

   // one word in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

   // count never passes the table depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[73:67]) <= MAX_EXTENTS || MAX_EXTENTS > 127)
      else $error("extent count past table depth");

   // failed items place nothing
   a_err_placed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != emot_pkg::STATUS_OK |-> rsp_tdata[137:74] == 64'd0)
      else $error("placed offset on failed item");

   // no reply straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("reply valid after reset");

endmodule

bind extent_map_overwrite_table emot_checker #(.MAX_EXTENTS(MAX_EXTENTS)) u_emot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
